FILE: hw/rtl/cmws_pkg.sv
// Shared constants, payload types and helpers for the command line word splitter.
package cmws_pkg;

	localparam int MAX_WORDS_DEFAULT = 2;
	localparam int WORD_SLOT_DEFAULT = 8;

	localparam int OUT_WORD_W = 56;
	localparam int LEN_W      = 3;
	localparam int COUNT_W    = 2;
	localparam int STATUS_W   = 2;
	localparam int NUM_SLOTS  = 2;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_NL    = 8'h0A;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_LONG = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MANY = 2'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_word_t;

	typedef struct packed {
		logic [OUT_WORD_W-1:0] first_word;
		logic [OUT_WORD_W-1:0] second_word;
		logic [LEN_W-1:0]      first_length;
		logic [LEN_W-1:0]      second_length;
		logic [COUNT_W-1:0]    words_found;
		logic [STATUS_W-1:0]   line_status;
	} line_result_t;

	function automatic logic is_separator(input logic [7:0] b);
		return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR);
	endfunction

endpackage

FILE: hw/rtl/cmws_stream_if.sv
// Valid/ready stream channel carrying one word of a given payload type.
interface cmws_stream_if #(
	parameter type data_t = logic [7:0]
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cmws_split.sv
// Line state of the splitter: phase, word and char indexes, word store, result view.
module cmws_split
	import cmws_pkg::*;
#(
	parameter int MAX_WORDS = MAX_WORDS_DEFAULT,
	parameter int WORD_SLOT = WORD_SLOT_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   rx_byte,
	output line_result_t res
);

	localparam int CHARS = WORD_SLOT - 1;
	localparam int WB    = 8 * CHARS;
	localparam int CW    = $clog2(WORD_SLOT);
	localparam int WIW   = $clog2(MAX_WORDS + 1);
	localparam logic [WIW-1:0] MAX_IDX   = WIW'(MAX_WORDS);
	localparam logic [CW-1:0]  CHAR_LIM  = CW'(CHARS);

	typedef enum logic [1:0] {PH_SKIP, PH_WORD, PH_TAIL, PH_DISCARD} phase_t;

	phase_t              phase_q, phase_d;
	logic [WIW-1:0]      word_index_q, word_index_d;
	logic [CW-1:0]       char_index_q, char_index_d;
	logic [WB-1:0]       store_q [NUM_SLOTS];
	logic [WB-1:0]       store_d [NUM_SLOTS];
	logic [CW-1:0]       len_q [NUM_SLOTS];
	logic [CW-1:0]       len_d [NUM_SLOTS];
	logic [STATUS_W-1:0] error_q, error_d;

	logic           sep;
	logic           in_word;
	logic [CW-1:0]  eff_char;
	logic [WIW-1:0] next_index;
	logic [WIW-1:0] found;

	assign sep        = is_separator(rx_byte);
	assign in_word    = (phase_q == PH_WORD) || ((phase_q == PH_SKIP) && !sep);
	assign eff_char   = (phase_q == PH_SKIP) ? '0 : char_index_q;
	assign next_index = WIW'(word_index_q + 1'b1);

	always_comb begin
		phase_d      = phase_q;
		word_index_d = word_index_q;
		char_index_d = char_index_q;
		error_d      = error_q;
		store_d      = store_q;
		len_d        = len_q;
		if (rx_byte == CHAR_NL) begin
			phase_d      = PH_SKIP;
			word_index_d = '0;
			char_index_d = '0;
			error_d      = STATUS_OK;
			for (int j = 0; j < NUM_SLOTS; j++) begin
				store_d[j] = '0;
				len_d[j]   = '0;
			end
		end else if (in_word) begin
			if (sep) begin
				word_index_d = next_index;
				char_index_d = '0;
				phase_d      = (next_index >= MAX_IDX) ? PH_TAIL : PH_SKIP;
			end else if (eff_char < CHAR_LIM) begin
				for (int j = 0; j < NUM_SLOTS; j++) begin
					if (word_index_q == WIW'(j)) begin
						for (int k = 0; k < CHARS; k++) begin
							if (eff_char == CW'(k)) begin
								store_d[j][8*k +: 8] = rx_byte;
							end
						end
						len_d[j] = CW'(eff_char + 1'b1);
					end
				end
				char_index_d = CW'(eff_char + 1'b1);
				phase_d      = PH_WORD;
			end else begin
				error_d = STATUS_LONG;
				phase_d = PH_DISCARD;
			end
		end else if ((phase_q == PH_TAIL) && !sep) begin
			error_d = STATUS_MANY;
			phase_d = PH_DISCARD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SKIP;
			word_index_q <= '0;
			char_index_q <= '0;
			error_q      <= STATUS_OK;
			for (int j = 0; j < NUM_SLOTS; j++) begin
				store_q[j] <= '0;
				len_q[j]   <= '0;
			end
		end else if (step) begin
			phase_q      <= phase_d;
			word_index_q <= word_index_d;
			char_index_q <= char_index_d;
			error_q      <= error_d;
			store_q      <= store_d;
			len_q        <= len_d;
		end
	end

	assign found = (phase_q == PH_WORD) ? next_index : word_index_q;

	always_comb begin
		res = '0;
		res.line_status = error_q;
		if (error_q == STATUS_OK) begin
			res.first_word    = OUT_WORD_W'(store_q[0]);
			res.second_word   = OUT_WORD_W'(store_q[1]);
			res.first_length  = LEN_W'(len_q[0]);
			res.second_length = LEN_W'(len_q[1]);
			res.words_found   = (int'(found) > 3) ? 2'd3 : COUNT_W'(found);
		end
	end

endmodule

FILE: hw/rtl/command_line_word_splitter.sv
// A newline word accepted on rx passes the byte register, then the result register that
// drives the output. Throughput: one byte word per cycle; the byte register and result
// register are split by the line state update, and a byte stalls only when a newline meets
// a full result register while result.ready is low. Reset (arst_n low, asynchronous) empties
// both registers and clears the line state and word store; bytes are taken from release on.
module command_line_word_splitter
	import cmws_pkg::*;
#(
	parameter int MAX_WORDS = MAX_WORDS_DEFAULT,
	parameter int WORD_SLOT = WORD_SLOT_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	cmws_stream_if.sink   rx,
	cmws_stream_if.source result
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         eol_s1;
	logic         adv;
	logic         step;
	line_result_t split_res;
	line_result_t res_q;
	logic         res_valid_q;

	assign eol_s1   = valid_s1 && (byte_s1 == CHAR_NL);
	assign adv      = !eol_s1 || !res_valid_q || result.ready;
	assign step     = valid_s1 && adv;
	assign rx.ready = adv;

	cmws_split #(
		.MAX_WORDS(MAX_WORDS),
		.WORD_SLOT(WORD_SLOT)
	) u_split (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.res     (split_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1 <= rx.valid;
			end
			if (step && eol_s1) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && rx.valid) begin
			byte_s1 <= rx.data.rx_byte;
		end
		if (step && eol_s1) begin
			res_q <= split_res;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule
